FILE: src/sss_pkg.sv
// shared types and constants for the swing step sequencer
// no dependencies; imported by swing_step_sequencer
`default_nettype none

package sss_pkg;

    // default store depth
    localparam int SSS_MAX_STEPS = 64;

    // fixed field widths
    localparam int LEVEL_W  = 16;
    localparam int INDEX_W  = 6;
    localparam int CFG_W    = 32;
    localparam int CFG_IDXW = 3;

    // command codes
    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    // step order codes
    localparam logic [1:0] ORDER_FWD  = 2'd0;
    localparam logic [1:0] ORDER_REV  = 2'd1;
    localparam logic [1:0] ORDER_RAND = 2'd2;

    // register indexes
    typedef enum logic [CFG_IDXW-1:0] {
        CFG_STEP_COUNT   = 3'd0,
        CFG_STEP_PERIOD  = 3'd1,
        CFG_SWING_AMOUNT = 3'd2,
        CFG_ORDER_MODE   = 3'd3,
        CFG_SMOOTH_COEFF = 3'd4,
        CFG_OUT_MIN      = 3'd5,
        CFG_OUT_MAX      = 3'd6,
        CFG_VOLUME       = 3'd7
    } t_cfg_idx;

    // register reset values
    localparam logic [6:0]  RST_STEP_COUNT   = 7'd16;
    localparam logic [31:0] RST_STEP_PERIOD  = 32'd2822400;
    localparam logic [7:0]  RST_SWING_AMOUNT = 8'd0;
    localparam logic [1:0]  RST_ORDER_MODE   = ORDER_FWD;
    localparam logic [15:0] RST_SMOOTH_COEFF = 16'd65387;
    localparam logic [15:0] RST_OUT_MIN      = 16'd0;
    localparam logic [15:0] RST_OUT_MAX      = 16'd32767;
    localparam logic [15:0] RST_VOLUME       = 16'd65535;

    // phase and random order
    localparam logic [31:0] ONE_SAMPLE = 32'd256;
    localparam logic [15:0] LFSR_TAPS  = 16'hB400;
    localparam logic [15:0] LFSR_SEED  = 16'hACE1;

    // tick sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_PHASE,
        S_ADV,
        S_READ,
        S_TARGET,
        S_SMA,
        S_SMB,
        S_SMC,
        S_MAP,
        S_ADD,
        S_GAIN,
        S_OUT
    } t_state;

endpackage

`default_nettype wire

FILE: src/swing_step_sequencer.sv
// swing step sequencer top level: step store, phase counter, smoothing and output scaling
// depends on sss_pkg
`default_nettype none

// Step sequencer modulation source. A tick request (cmd 0) adds one sample to a Q24.8 phase
// counter; on crossing the step period the position moves forward, in reverse or to an
// LFSR-picked step, and swing lengthens even steps and shortens odd ones. The level of the
// current step (or of the previous step when tied) is one-pole smoothed, mapped into
// out_min..out_max and scaled by volume, and one result leaves for every tick. A write request
// (cmd 1) stores one step entry without leaving idle and gives no result. After acceptance a
// tick walks 11 sequencer states before the block takes the next request, a chain set by the
// dependent multiplies (swing period, two smoothing products, range map, gain) that share one
// sequencer, with the step store read among them; the block then returns to idle to take the
// next request. The last state waits while an earlier result is still unaccepted in the output
// register, so a stalled receiver lengthens a tick by the length of the stall. The step store
// is one memory with two registered read ports (current and previous step); per-entry valid
// bits, cleared at reset, make never written entries read as zero, so there is no clearing
// pass. The result sits in an output register, so a new request is taken while an earlier
// result still waits.
module swing_step_sequencer
    import sss_pkg::*;
#(
    parameter int MAX_STEPS = SSS_MAX_STEPS
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // request channel
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire logic                i_cmd,
    input  wire logic [INDEX_W-1:0]  i_step_index,
    input  wire logic [LEVEL_W-1:0]  i_step_level,
    input  wire logic                i_step_gate,
    input  wire logic                i_step_tie,
    // result channel
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output logic signed [15:0]       o_sample,
    output logic [INDEX_W-1:0]       o_step_position,
    output logic                     o_step_advanced,
    // configuration
    input  wire logic                i_cfg_we,
    input  wire logic [CFG_IDXW-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0]    i_cfg_data
);

    // position index, count range and a compare width that holds both
    localparam int POS_W = $clog2(MAX_STEPS);
    localparam int CNT_W = $clog2(MAX_STEPS + 1);
    localparam int CW    = (CNT_W > 7) ? CNT_W : 7;
    localparam int IW    = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;
    localparam int ENT_W = LEVEL_W + 2;

    // step count clamped to 1..MAX_STEPS
    function automatic logic [CNT_W-1:0] f_eff_count(input logic [6:0] sc);
        logic [CW-1:0] v;
        begin
            v = CW'(sc);
            if (v == '0)
                return CNT_W'(1);
            else if (v > CW'(MAX_STEPS))
                return CNT_W'(MAX_STEPS);
            else
                return CNT_W'(v);
        end
    endfunction

    // configuration registers
    logic [6:0]  r_step_count;
    logic [31:0] r_step_period;
    logic [7:0]  r_swing;
    logic [1:0]  r_order;
    logic [15:0] r_coeff;
    logic [15:0] r_out_min;
    logic [15:0] r_out_max;
    logic [15:0] r_volume;

    // sequencer state
    t_state      r_state, n_state;
    logic [POS_W-1:0] r_pos;
    logic [31:0] r_phase;
    logic [31:0] r_active;
    logic [15:0] r_target;
    logic [23:0] r_smooth;
    logic [15:0] r_lfsr;
    logic        r_adv;
    logic        r_swing_upd;
    logic [MAX_STEPS-1:0] r_valid;

    // step store
    logic [ENT_W-1:0] mem [MAX_STEPS];
    logic [ENT_W-1:0] r_rd_cur, r_rd_prv;
    logic             r_vld_cur, r_vld_prv;

    // datapath pipeline registers
    logic [41:0]        r_swing_prod;
    logic [39:0]        r_ma;
    logic [32:0]        r_mb;
    logic signed [16:0] r_lo;
    logic [15:0]        r_diff;
    logic [39:0]        r_mmul;
    logic signed [16:0] r_mapped;
    logic signed [33:0] r_gain;

    // result register
    logic               r_out_vld;
    logic signed [15:0] r_out_sample;
    logic [INDEX_W-1:0] r_out_pos;
    logic               r_out_adv;

    logic in_acc, load_ok, wr_ok;
    logic [CNT_W-1:0] cnt;
    logic [POS_W-1:0] prv_addr;

    // combinational datapath terms
    logic [31:0] period_raw, period;
    logic [32:0] phase_sum;
    logic [15:0] lfsr_next;
    logic [16+CNT_W-1:0] rand_prod;
    logic [POS_W-1:0] pos_next;
    logic [9:0]  swing_f;
    logic [32:0] swing_p;
    logic [31:0] swing_sat;
    logic        gate_cur, gate_prv, tie_cur;
    logic [40:0] smooth_acc;
    logic signed [16:0] lo_s, hi_s;
    logic [40:0] map_acc;
    logic signed [33:0] gain_rnd;

    assign in_acc     = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == S_IDLE);
    assign load_ok    = !r_out_vld || i_out_ready;
    assign wr_ok      = (IW'(i_step_index) < IW'(MAX_STEPS));
    assign cnt        = f_eff_count(r_step_count);
    assign prv_addr   = r_pos - POS_W'(1);

    assign o_out_valid     = r_out_vld;
    assign o_sample        = r_out_sample;
    assign o_step_position = r_out_pos;
    assign o_step_advanced = r_out_adv;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_state <= S_IDLE;
        else
            r_state <= n_state;
    end

    // next state: a tick walks the whole chain, a write stays idle
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (in_acc && i_cmd == CMD_TICK) n_state = S_PHASE;
            S_PHASE:  n_state = S_ADV;
            S_ADV:    n_state = S_READ;
            S_READ:   n_state = S_TARGET;
            S_TARGET: n_state = S_SMA;
            S_SMA:    n_state = S_SMB;
            S_SMB:    n_state = S_SMC;
            S_SMC:    n_state = S_MAP;
            S_MAP:    n_state = S_ADD;
            S_ADD:    n_state = S_GAIN;
            S_GAIN:   n_state = S_OUT;
            S_OUT:    if (load_ok) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        // effective period, never below one sample
        period_raw = (r_active != '0) ? r_active : r_step_period;
        period     = (period_raw < ONE_SAMPLE) ? ONE_SAMPLE : period_raw;
        phase_sum  = {1'b0, r_phase} + {1'b0, ONE_SAMPLE};

        // galois lfsr step and random position
        lfsr_next = {1'b0, r_lfsr[15:1]} ^ (r_lfsr[0] ? LFSR_TAPS : 16'h0000);
        rand_prod = (16 + CNT_W)'(lfsr_next) * (16 + CNT_W)'(cnt);

        // forward / reverse with wrap
        if (r_order == ORDER_REV) begin
            if (r_pos == '0 || CW'(r_pos) > CW'(cnt))
                pos_next = POS_W'(cnt - CNT_W'(1));
            else
                pos_next = r_pos - POS_W'(1);
        end else begin
            if (CW'(r_pos) + CW'(1) >= CW'(cnt))
                pos_next = '0;
            else
                pos_next = r_pos + POS_W'(1);
        end

        // swing factor from the new position, saturated and floored period
        swing_f   = r_pos[0] ? (10'd512 - 10'(r_swing)) : (10'd512 + 10'(r_swing));
        swing_p   = r_swing_prod[41:9];
        if (swing_p[32])
            swing_sat = 32'hFFFF_FFFF;
        else if (swing_p[31:0] < ONE_SAMPLE)
            swing_sat = ONE_SAMPLE;
        else
            swing_sat = swing_p[31:0];

        // entry flags, unwritten entries read as zero
        gate_cur = r_vld_cur && r_rd_cur[1];
        tie_cur  = r_vld_cur && r_rd_cur[0];
        gate_prv = r_vld_prv && r_rd_prv[1];

        // one-pole sum and output range
        smooth_acc = 41'(r_ma) + {r_mb, 8'd0} + 41'd32768;
        lo_s = 17'(signed'(r_out_min));
        hi_s = 17'(signed'(r_out_max));
        map_acc  = 41'(r_mmul) + 41'd8388608;
        gain_rnd = r_gain + 34'sd32768;
    end

    // step store: one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (in_acc && i_cmd == CMD_WRITE && wr_ok)
            mem[POS_W'(i_step_index)] <= {i_step_level, i_step_gate, i_step_tie};
        if (r_state == S_READ) begin
            r_rd_cur <= mem[r_pos];
            r_rd_prv <= mem[prv_addr];
        end
    end

    // control state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_count  <= RST_STEP_COUNT;
            r_step_period <= RST_STEP_PERIOD;
            r_swing       <= RST_SWING_AMOUNT;
            r_order       <= RST_ORDER_MODE;
            r_coeff       <= RST_SMOOTH_COEFF;
            r_out_min     <= RST_OUT_MIN;
            r_out_max     <= RST_OUT_MAX;
            r_volume      <= RST_VOLUME;
            r_pos         <= '0;
            r_phase       <= '0;
            r_active      <= '0;
            r_target      <= '0;
            r_smooth      <= '0;
            r_lfsr        <= LFSR_SEED;
            r_adv         <= 1'b0;
            r_swing_upd   <= 1'b0;
            r_valid       <= '0;
            r_vld_cur     <= 1'b0;
            r_vld_prv     <= 1'b0;
            r_out_vld     <= 1'b0;
        end else begin
            // the user must write registers only while idle; the block itself does not enforce this
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_STEP_COUNT: begin
                        r_step_count <= i_cfg_data[6:0];
                        if (CW'(r_pos) >= CW'(f_eff_count(i_cfg_data[6:0])))
                            r_pos <= '0;
                    end
                    CFG_STEP_PERIOD: begin
                        r_step_period <= i_cfg_data;
                        r_active      <= '0;
                    end
                    CFG_SWING_AMOUNT: r_swing   <= i_cfg_data[7:0];
                    CFG_ORDER_MODE:   r_order   <= i_cfg_data[1:0];
                    CFG_SMOOTH_COEFF: r_coeff   <= i_cfg_data[15:0];
                    CFG_OUT_MIN:      r_out_min <= i_cfg_data[15:0];
                    CFG_OUT_MAX:      r_out_max <= i_cfg_data[15:0];
                    CFG_VOLUME:       r_volume  <= i_cfg_data[15:0];
                    default: ;
                endcase
            end

            if (in_acc && i_cmd == CMD_WRITE && wr_ok)
                r_valid[POS_W'(i_step_index)] <= 1'b1;

            case (r_state)
                // phase accumulate, at most one boundary per tick
                S_PHASE: begin
                    if (phase_sum >= {1'b0, period}) begin
                        r_phase <= 32'(phase_sum - {1'b0, period});
                        r_adv   <= 1'b1;
                    end else begin
                        r_phase <= phase_sum[31:0];
                        r_adv   <= 1'b0;
                    end
                end
                // move the position
                S_ADV: begin
                    if (r_adv) begin
                        if (r_order == ORDER_RAND) begin
                            r_lfsr <= lfsr_next;
                            r_pos  <= rand_prod[16 +: POS_W];
                        end else begin
                            r_pos <= pos_next;
                        end
                    end
                end
                // store read issued, swing update decided
                S_READ: begin
                    r_vld_cur   <= r_valid[r_pos];
                    r_vld_prv   <= r_valid[prv_addr];
                    r_swing_upd <= r_adv && (r_order != ORDER_RAND) && (r_swing != '0);
                end
                // pick the target level
                S_TARGET: begin
                    if (r_swing_upd)
                        r_active <= swing_sat;
                    if (CW'(r_pos) < CW'(cnt)) begin
                        if (!gate_cur)
                            r_target <= '0;
                        else if (tie_cur && r_pos != '0 && gate_prv)
                            r_target <= r_rd_prv[ENT_W-1:2];
                        else
                            r_target <= r_rd_cur[ENT_W-1:2];
                    end
                end
                S_SMC: r_smooth <= smooth_acc[39:16];
                default: ;
            endcase

            // result register
            if (r_state == S_OUT && load_ok)
                r_out_vld <= 1'b1;
            else if (i_out_ready)
                r_out_vld <= 1'b0;
        end
    end

    // multiply chain and result payload
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_READ: r_swing_prod <= 42'(r_step_period) * 42'(swing_f);
            S_SMA:  r_ma <= 40'(r_coeff) * 40'(r_smooth);
            S_SMB:  r_mb <= (33'h1_0000 - 33'(r_coeff)) * 33'(r_target);
            S_SMC: begin
                // ordered bounds
                if (lo_s > hi_s) begin
                    r_lo   <= hi_s;
                    r_diff <= 16'(lo_s - hi_s);
                end else begin
                    r_lo   <= lo_s;
                    r_diff <= 16'(hi_s - lo_s);
                end
            end
            S_MAP:  r_mmul   <= 40'(r_smooth) * 40'(r_diff);
            S_ADD:  r_mapped <= r_lo + signed'({1'b0, map_acc[39:24]});
            S_GAIN: r_gain   <= 34'(r_mapped) * signed'({18'd0, r_volume});
            S_OUT: begin
                if (load_ok) begin
                    r_out_sample <= gain_rnd[31:16];
                    r_out_pos    <= INDEX_W'(r_pos);
                    r_out_adv    <= r_adv;
                end
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
// testbench for swing_step_sequencer: directed and random request streams, each result checked
// against a predictor of the sequencer kept inside this file
// depends on sss_pkg and the swing_step_sequencer rtl
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import sss_pkg::*;

    localparam int STEPS        = SSS_MAX_STEPS;
    localparam int SETTLE_CYC   = 16;         // longer than a tick or a write takes
    localparam int HOLD_OFF_CYC = 300;        // long receiver stall, fills the block
    localparam int MAX_PRINT    = 40;
    localparam int LIMIT_NS     = 4_000_000;  // run limit, with a 4 ns clock period

    // the order code that the package leaves unnamed, handled as forward
    localparam logic [1:0] ORDER_SPARE = 2'd3;

    // expected fields of one tick result
    typedef struct packed {
        logic signed [15:0]   sample;
        logic [INDEX_W-1:0]   position;
        logic                 advanced;
    } t_tick_result;

    // clock, reset and block ports, all known from time zero
    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_ready;
    logic                i_cmd = CMD_TICK;
    logic [INDEX_W-1:0]  i_step_index = '0;
    logic [LEVEL_W-1:0]  i_step_level = '0;
    logic                i_step_gate = 1'b0;
    logic                i_step_tie = 1'b0;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    logic signed [15:0]  o_sample;
    logic [INDEX_W-1:0]  o_step_position;
    logic                o_step_advanced;
    logic                i_cfg_we = 1'b0;
    logic [CFG_IDXW-1:0] i_cfg_idx = '0;
    logic [CFG_W-1:0]    i_cfg_data = '0;

    swing_step_sequencer #(.MAX_STEPS(STEPS)) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_cmd           (i_cmd),
        .i_step_index    (i_step_index),
        .i_step_level    (i_step_level),
        .i_step_gate     (i_step_gate),
        .i_step_tie      (i_step_tie),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_sample        (o_sample),
        .o_step_position (o_step_position),
        .o_step_advanced (o_step_advanced),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // idling and hold-off controls, set by the test tasks
    int tx_idle_pct  = 9;
    int rx_idle_pct  = 67;
    int hold_request = 0;
    int hold_left    = 0;

    // run statistics
    int n_fail     = 0;
    int n_requests = 0;
    int n_ticks    = 0;
    int n_writes   = 0;
    int n_results  = 0;
    int n_advanced = 0;
    int n_cfg      = 0;
    int n_settings = 0;

    // results predicted for accepted ticks, oldest first
    t_tick_result pending_samples[$];

    // ---------------------------------------------------------------------------------------
    // predictor: register copy and sequencer state
    // ---------------------------------------------------------------------------------------
    logic [6:0]  set_count;
    logic [31:0] set_period;
    logic [7:0]  set_swing;
    logic [1:0]  set_order;
    logic [15:0] set_coeff;
    logic [15:0] set_min;
    logic [15:0] set_max;
    logic [15:0] set_volume;

    logic [15:0] mdl_levels [STEPS];
    bit          mdl_gates  [STEPS];
    bit          mdl_ties   [STEPS];
    int unsigned mdl_pos;
    logic [31:0] mdl_phase;
    logic [31:0] mdl_active;   // swung period, zero means the plain period
    logic [15:0] mdl_target;
    logic [23:0] mdl_smooth;
    logic [15:0] mdl_lfsr;

    function automatic void model_reset();
        set_count  = RST_STEP_COUNT;
        set_period = RST_STEP_PERIOD;
        set_swing  = RST_SWING_AMOUNT;
        set_order  = RST_ORDER_MODE;
        set_coeff  = RST_SMOOTH_COEFF;
        set_min    = RST_OUT_MIN;
        set_max    = RST_OUT_MAX;
        set_volume = RST_VOLUME;
        for (int k = 0; k < STEPS; k++) begin
            mdl_levels[k] = '0;
            mdl_gates[k]  = 1'b0;
            mdl_ties[k]   = 1'b0;
        end
        mdl_pos    = 0;
        mdl_phase  = '0;
        mdl_active = '0;
        mdl_target = '0;
        mdl_smooth = '0;
        mdl_lfsr   = LFSR_SEED;
    endfunction

    // a count of zero plays one step, anything above the store plays the whole store
    function automatic int unsigned used_count();
        if (set_count == 0) return 1;
        if (set_count > STEPS) return STEPS;
        return 32'(set_count);
    endfunction

    function automatic void model_config(t_cfg_idx idx, logic [31:0] data);
        case (idx)
            CFG_STEP_COUNT: begin
                set_count = data[6:0];
                if (mdl_pos >= used_count()) mdl_pos = 0;
            end
            CFG_STEP_PERIOD: begin
                set_period = data;
                mdl_active = '0;
            end
            CFG_SWING_AMOUNT: set_swing  = data[7:0];
            CFG_ORDER_MODE:   set_order  = data[1:0];
            CFG_SMOOTH_COEFF: set_coeff  = data[15:0];
            CFG_OUT_MIN:      set_min    = data[15:0];
            CFG_OUT_MAX:      set_max    = data[15:0];
            CFG_VOLUME:       set_volume = data[15:0];
            default: ;
        endcase
    endfunction

    // step boundary: new position, then the swung length of the step just entered
    function automatic void move_position();
        int unsigned cnt;
        logic        lsb;
        logic [63:0] factor;
        logic [63:0] swung;
        cnt = used_count();
        if (set_order == ORDER_RAND) begin
            // galois lfsr, scaled into the active steps; swing plays no part here
            lsb = mdl_lfsr[0];
            mdl_lfsr = mdl_lfsr >> 1;
            if (lsb) mdl_lfsr = mdl_lfsr ^ LFSR_TAPS;
            mdl_pos = (32'(mdl_lfsr) * cnt) >> 16;
            return;
        end
        if (set_order == ORDER_REV) begin
            if (mdl_pos == 0 || mdl_pos > cnt) mdl_pos = cnt - 1;
            else mdl_pos = mdl_pos - 1;
        end else begin
            if (mdl_pos + 1 >= cnt) mdl_pos = 0;
            else mdl_pos = mdl_pos + 1;
        end
        if (set_swing != 0) begin
            // even steps lengthened, odd steps shortened, saturated and floored at one sample
            factor = mdl_pos[0] ? 64'(512 - set_swing) : 64'(512 + set_swing);
            swung = (64'(set_period) * factor) >> 9;
            if (swung > 64'hFFFF_FFFF) swung = 64'hFFFF_FFFF;
            if (swung < 64'(ONE_SAMPLE)) swung = 64'(ONE_SAMPLE);
            mdl_active = swung[31:0];
        end
    endfunction

    function automatic t_tick_result predict_tick_output();
        int unsigned  cnt;
        logic [31:0]  period;
        logic [32:0]  phase_sum;
        logic [63:0]  acc;
        int           lo;
        int           hi;
        int           swap;
        int           mapped;
        longint       vol;
        longint       prod;
        t_tick_result res;
        res.advanced = 1'b0;
        cnt = used_count();
        period = (mdl_active != 0) ? mdl_active : set_period;
        if (period < ONE_SAMPLE) period = ONE_SAMPLE;
        // 33-bit sum so the phase never wraps
        phase_sum = {1'b0, mdl_phase} + {1'b0, ONE_SAMPLE};
        if (phase_sum >= {1'b0, period}) begin
            phase_sum = phase_sum - {1'b0, period};
            move_position();
            res.advanced = 1'b1;
        end
        mdl_phase = phase_sum[31:0];

        // target level: gated own level, previous level when tied to a gated step
        if (mdl_pos < cnt && mdl_pos < STEPS) begin
            if (!mdl_gates[mdl_pos])
                mdl_target = '0;
            else if (mdl_ties[mdl_pos] && mdl_pos > 0 && mdl_gates[mdl_pos - 1])
                mdl_target = mdl_levels[mdl_pos - 1];
            else
                mdl_target = mdl_levels[mdl_pos];
        end

        // one-pole smoothing in q0.24
        acc = 64'(set_coeff) * 64'(mdl_smooth)
            + (64'd65536 - 64'(set_coeff)) * (64'(mdl_target) << 8) + 64'd32768;
        mdl_smooth = acc[39:16];

        // range map, bounds swapped when given the wrong way round
        lo = int'($signed(set_min));
        hi = int'($signed(set_max));
        if (lo > hi) begin
            swap = lo;
            lo = hi;
            hi = swap;
        end
        acc = 64'(mdl_smooth) * 64'(hi - lo) + 64'd8388608;
        mapped = lo + int'(acc[63:24]);

        // volume with rounding towards minus infinity after the half offset
        vol = longint'(set_volume);
        prod = longint'(mapped) * vol;
        prod = (prod + 64'sd32768) >>> 16;
        res.sample = prod[15:0];
        res.position = mdl_pos[INDEX_W-1:0];
        return res;
    endfunction

    // ---------------------------------------------------------------------------------------
    // mismatch reporting and result checking
    // ---------------------------------------------------------------------------------------
    task automatic report_mismatch(string what, longint got, longint want);
        n_fail++;
        if (n_fail <= MAX_PRINT)
            $display("mismatch at %0t ns: %s got %0d want %0d", $time, what, got, want);
    endtask

    // compare each accepted result with the oldest prediction
    always @(posedge i_clk) begin : result_check
        t_tick_result want;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready) begin
            n_results++;
            if (o_step_advanced === 1'b1) n_advanced++;
            if (pending_samples.size() == 0) begin
                report_mismatch("result with no tick pending, sample", longint'(o_sample), 0);
            end else begin
                want = pending_samples.pop_front();
                if (o_sample !== want.sample)
                    report_mismatch("sample", longint'(o_sample), longint'(want.sample));
                if (o_step_position !== want.position)
                    report_mismatch("step_position", longint'(o_step_position),
                                    longint'(want.position));
                if (o_step_advanced !== want.advanced)
                    report_mismatch("step_advanced", longint'(o_step_advanced),
                                    longint'(want.advanced));
            end
        end
    end

    // receiver: random stalls, or a long hold-off counted here when one is requested
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_out_ready <= 1'b0;
            hold_left = hold_left - 1;
        end else if (hold_request > 0) begin
            i_out_ready <= 1'b0;
            hold_left = hold_request - 1;
            hold_request = 0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // ---------------------------------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------------------------------

    // offer one request and hold it until taken; valid is left high so that a request
    // right behind it follows with no gap
    task automatic send_request(logic cmd, logic [INDEX_W-1:0] idx, logic [LEVEL_W-1:0] level,
                                logic gate, logic tie);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_cmd        <= cmd;
        i_step_index <= idx;
        i_step_level <= level;
        i_step_gate  <= gate;
        i_step_tie   <= tie;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        n_requests++;
        if (cmd == CMD_WRITE) begin
            mdl_levels[idx] = level;
            mdl_gates[idx]  = gate;
            mdl_ties[idx]   = tie;
            n_writes++;
        end else begin
            pending_samples.push_back(predict_tick_output());
            n_ticks++;
        end
    endtask

    // tick with noise in the fields that a tick ignores
    task automatic send_tick();
        send_request(CMD_TICK, INDEX_W'($urandom_range(63)), LEVEL_W'($urandom_range(65535)),
                     1'($urandom_range(1)), 1'($urandom_range(1)));
    endtask

    task automatic send_random_write();
        logic [INDEX_W-1:0] idx;
        logic [LEVEL_W-1:0] level;
        int                 r;
        // favour the first steps, where most counts play
        idx = ($urandom_range(1) == 0) ? INDEX_W'($urandom_range(7))
                                       : INDEX_W'($urandom_range(63));
        r = $urandom_range(99);
        if (r < 10) level = '0;
        else if (r < 20) level = '1;
        else level = LEVEL_W'($urandom_range(65535));
        send_request(CMD_WRITE, idx, level, $urandom_range(99) < 70, $urandom_range(99) < 40);
    endtask

    // stop offering, let every predicted result drain and the block fall idle
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (pending_samples.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic cfg_write(t_cfg_idx idx, logic [31:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        model_config(idx, data);
        n_cfg++;
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // new random setting, written while idle; each register written or left as it was
    task automatic pick_setting(bit every);
        int r;
        wait_idle();
        n_settings++;
        if (every || $urandom_range(1)) begin
            r = $urandom_range(99);
            if (r < 70) cfg_write(CFG_STEP_COUNT, $urandom_range(8, 1));
            else if (r < 80) cfg_write(CFG_STEP_COUNT, $urandom_range(64, 9));
            else if (r < 90) cfg_write(CFG_STEP_COUNT, 0);
            else cfg_write(CFG_STEP_COUNT, $urandom_range(127, 65));
        end
        if (every || $urandom_range(1)) begin
            // mostly short steps so that boundaries come often
            r = $urandom_range(99);
            if (r < 60) cfg_write(CFG_STEP_PERIOD, $urandom_range(1536, 256));
            else if (r < 75) cfg_write(CFG_STEP_PERIOD, $urandom_range(255));
            else if (r < 90) cfg_write(CFG_STEP_PERIOD, $urandom_range(8192, 1537));
            else cfg_write(CFG_STEP_PERIOD, $urandom());
        end
        if (every || $urandom_range(1)) begin
            r = $urandom_range(99);
            if (r < 30) cfg_write(CFG_SWING_AMOUNT, 0);
            else if (r < 40) cfg_write(CFG_SWING_AMOUNT, 255);
            else cfg_write(CFG_SWING_AMOUNT, $urandom_range(255));
        end
        if (every || $urandom_range(1))
            cfg_write(CFG_ORDER_MODE, $urandom_range(3));
        if (every || $urandom_range(1)) begin
            r = $urandom_range(99);
            if (r < 15) cfg_write(CFG_SMOOTH_COEFF, 0);
            else if (r < 25) cfg_write(CFG_SMOOTH_COEFF, 65535);
            else if (r < 60) cfg_write(CFG_SMOOTH_COEFF, $urandom_range(65535, 60000));
            else cfg_write(CFG_SMOOTH_COEFF, $urandom_range(65535));
        end
        if (every || $urandom_range(1)) begin
            r = $urandom_range(99);
            if (r < 10) cfg_write(CFG_OUT_MIN, 32'h8000);
            else if (r < 20) cfg_write(CFG_OUT_MIN, 32'h7FFF);
            else cfg_write(CFG_OUT_MIN, $urandom_range(65535));
        end
        if (every || $urandom_range(1)) begin
            r = $urandom_range(99);
            if (r < 10) cfg_write(CFG_OUT_MAX, 32'h8000);
            else if (r < 20) cfg_write(CFG_OUT_MAX, 32'h7FFF);
            else cfg_write(CFG_OUT_MAX, $urandom_range(65535));
        end
        if (every || $urandom_range(1)) begin
            r = $urandom_range(99);
            if (r < 10) cfg_write(CFG_VOLUME, 0);
            else if (r < 25) cfg_write(CFG_VOLUME, 65535);
            else cfg_write(CFG_VOLUME, $urandom_range(65535));
        end
    endtask

    // ---------------------------------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------------------------------

    // field extremes, every order mode, tie and gate cases, out-of-range counts and periods
    task automatic test_directed_cases();
        tx_idle_pct = 0;
        rx_idle_pct = 50;
        n_settings++;
        // reset setting: steps far longer than the run, all entries still clear
        repeat (2) send_tick();
        // tie on step zero is ignored; tie after a gated step borrows its level;
        // an ungated step is silent; tie after an ungated step keeps its own level
        send_request(CMD_WRITE, 6'd0, 16'hFFFF, 1'b1, 1'b1);
        send_request(CMD_WRITE, 6'd1, 16'h1234, 1'b1, 1'b1);
        send_request(CMD_WRITE, 6'd2, 16'h8000, 1'b0, 1'b1);
        send_request(CMD_WRITE, 6'd3, 16'h4321, 1'b1, 1'b1);
        wait_idle();
        // one sample per step, no smoothing, full signed range
        n_settings++;
        cfg_write(CFG_STEP_COUNT, 4);
        cfg_write(CFG_STEP_PERIOD, ONE_SAMPLE);
        cfg_write(CFG_SMOOTH_COEFF, 0);
        cfg_write(CFG_OUT_MIN, 32'h8000);
        cfg_write(CFG_OUT_MAX, 32'h7FFF);
        cfg_write(CFG_VOLUME, 32'hFFFF);
        repeat (5) send_tick();
        wait_idle();
        // reverse with wrap, bounds given the wrong way round
        n_settings++;
        cfg_write(CFG_ORDER_MODE, 32'(ORDER_REV));
        cfg_write(CFG_OUT_MIN, 32'h7FFF);
        cfg_write(CFG_OUT_MAX, 32'h8000);
        cfg_write(CFG_VOLUME, 32'h8000);
        repeat (3) send_tick();
        wait_idle();
        // spare order code runs forward; full swing drives odd steps onto the one-sample floor
        n_settings++;
        cfg_write(CFG_ORDER_MODE, 32'(ORDER_SPARE));
        cfg_write(CFG_SWING_AMOUNT, 255);
        cfg_write(CFG_SMOOTH_COEFF, 32'hFFFF);
        cfg_write(CFG_VOLUME, 0);
        repeat (4) send_tick();
        wait_idle();
        // random order over a count above the store, period below one sample
        n_settings++;
        cfg_write(CFG_ORDER_MODE, 32'(ORDER_RAND));
        cfg_write(CFG_STEP_COUNT, 127);
        cfg_write(CFG_STEP_PERIOD, 0);
        cfg_write(CFG_SMOOTH_COEFF, 32768);
        cfg_write(CFG_VOLUME, 32'hFFFF);
        send_request(CMD_WRITE, 6'd63, 16'hFFFF, 1'b1, 1'b1);
        repeat (3) send_tick();
        wait_idle();
        // count of zero pulls the position back to step zero; longest possible step
        n_settings++;
        cfg_write(CFG_STEP_COUNT, 0);
        cfg_write(CFG_ORDER_MODE, 32'(ORDER_FWD));
        cfg_write(CFG_SWING_AMOUNT, 0);
        cfg_write(CFG_STEP_PERIOD, 32'hFFFF_FFFF);
        repeat (2) send_tick();
    endtask

    // random segments under one idling regime, a fresh setting before each segment
    task automatic test_random_regime(int tx_pct, int rx_pct, int items);
        int left;
        int seg;
        left = items;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        while (left > 0) begin
            pick_setting(left == items);
            seg = $urandom_range(80, 40);
            if (seg > left) seg = left;
            for (int k = 0; k < seg; k++) begin
                if ($urandom_range(99) < 20) send_random_write();
                else send_tick();
            end
            left = left - seg;
        end
    endtask

    // receiver holds off while ticks keep coming, so the block backs up onto its input
    task automatic test_output_hold_off();
        wait_idle();
        n_settings++;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        cfg_write(CFG_STEP_COUNT, 5);
        cfg_write(CFG_STEP_PERIOD, 32'd512);
        cfg_write(CFG_ORDER_MODE, 32'(ORDER_FWD));
        hold_request = HOLD_OFF_CYC;
        repeat (20) send_tick();
    endtask

    // ---------------------------------------------------------------------------------------
    // sequence of tests and verdict
    // ---------------------------------------------------------------------------------------
    initial begin
        model_reset();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_cases();
        test_random_regime(9, 67, 570);
        test_random_regime(67, 9, 570);
        test_random_regime(0, 0, 570);
        test_output_hold_off();

        // drain and watch a little longer for stray results
        wait_idle();
        if (pending_samples.size() != 0)
            report_mismatch("ticks left without a result", longint'(pending_samples.size()), 0);

        $display("covered %0d requests (%0d ticks, %0d step writes), %0d results checked,",
                 n_requests, n_ticks, n_writes, n_results);
        $display("%0d at a step boundary; %0d register writes over %0d settings, %0d-cycle stall",
                 n_advanced, n_cfg, n_settings, HOLD_OFF_CYC);
        if (n_fail == 0) begin
            $display("PASS swing_step_sequencer");
        end else begin
            $display("FAIL swing_step_sequencer");
        end
        $finish;
    end

    // run limit, far above the slowest correct run
    initial begin
        #LIMIT_NS;
        $display("FAIL swing_step_sequencer");
        $finish;
    end

endmodule

FILE: sim.f
src/sss_pkg.sv
src/swing_step_sequencer.sv
tb/tb_top.sv
